// ===== src/hmmd_pkg.sv =====
// Package for the handheld memory map decoder.
// Holds the address map constants and the byte store port types.
// Depends on nothing; hmmd_store and the top level use it.
`default_nettype none

package hmmd_pkg;

	// Address map boundaries.
	localparam logic [15:0] ROM_END        = 16'h8000;
	localparam logic [15:0] ECHO_START     = 16'hE000;
	localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
	localparam logic [15:0] OAM_START      = 16'hFE00;
	localparam logic [15:0] UNUSABLE_START = 16'hFEA0;
	localparam logic [15:0] IO_START       = 16'hFF00;
	localparam logic [15:0] HRAM_START     = 16'hFF80;
	localparam logic [15:0] DISP_FIRST     = 16'hFF40;
	localparam logic [15:0] DISP_LAST      = 16'hFF4B;
	localparam logic [15:0] DISP_LINE      = 16'hFF44;
	localparam logic [7:0]  OPEN_BUS       = 8'hFF;

	// Access kinds.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Byte store geometry: it covers 0x8000-0xFFFF.
	localparam int STORE_DEPTH = 32768;
	localparam int STORE_AW    = 15;
	localparam int DISP_COUNT  = 12;
	localparam int DISP_AW     = 4;

	typedef logic [STORE_AW-1:0] store_addr_t;

	// Write port of the byte store.
	typedef struct packed {
		logic        en;
		store_addr_t addr;
		logic [7:0]  data;
	} store_wr_t;

	// Read port of the byte store.
	typedef struct packed {
		logic        en;
		store_addr_t addr;
	} store_rd_t;

	// Control carried with an access while its store read is in flight.
	typedef struct packed {
		logic       use_mem;
		logic [7:0] imm_byte;
		logic       cart;
		logic       drop;
	} pend_t;

endpackage

`default_nettype wire

// ===== src/hmmd_access_if.sv =====
// Channel that carries one bus access word into the decoder.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface hmmd_access_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] bus_address;
	logic [7:0]  write_byte;

	modport source (output valid, output command, output bus_address, output write_byte,
		input ready);
	modport sink (input valid, input command, input bus_address, input write_byte,
		output ready);
endinterface

`default_nettype wire

// ===== src/hmmd_result_if.sv =====
// Channel that carries one result word out of the decoder.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface hmmd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       to_cartridge;
	logic       write_dropped;

	modport source (output valid, output read_byte, output to_cartridge, output write_dropped,
		input ready);
	modport sink (input valid, input read_byte, input to_cartridge, input write_dropped,
		output ready);
endinterface

`default_nettype wire

// ===== src/hmmd_store.sv =====
// Byte store of the decoder: 32768 x 8 synchronous memory.
// One write port and one read port with registered read data; uses hmmd_pkg.
`default_nettype none

module hmmd_store (
	input  wire logic               clk,
	input  wire hmmd_pkg::store_wr_t wr,
	input  wire hmmd_pkg::store_rd_t rd,
	output logic [7:0]              rdata_q
);

	logic [7:0] mem [hmmd_pkg::STORE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/handheld_memory_map_decoder.sv =====
// Top level of the handheld memory map decoder.
// Uses hmmd_pkg, hmmd_access_if, hmmd_result_if and hmmd_store.
//
//   Channel  Dir  Word
//   access   in   command, bus_address[15:0], write_byte[7:0]
//   result   out  read_byte[7:0], to_cartridge, write_dropped
//
// One access is taken per cycle while access.ready is high; the store read and the
// pending stage are registered on acceptance, and the output register loads from
// them when the pending stage moves on. After reset the byte store is cleared one
// entry a cycle, and no access is accepted until every entry is cleared. A stalled
// result holds the pending stage; after the clearing pass, access.ready drops only
// while the output register is full and stalled and the pending stage has a word.
`default_nettype none

module handheld_memory_map_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hmmd_access_if.sink   access,
	hmmd_result_if.source result
);

	// Clearing pass state.
	logic                  clearing_q;
	hmmd_pkg::store_addr_t clr_cnt_q;

	// Display registers.
	logic [7:0] disp_q [hmmd_pkg::DISP_COUNT];

	// Pending stage and output register.
	logic            valid_s1;
	hmmd_pkg::pend_t pend_s1;
	logic            out_valid_q;
	logic [7:0]      read_byte_q;
	logic            cart_q;
	logic            drop_q;

	logic                  take;
	logic                  move_s1;
	logic                  is_write;
	logic                  in_rom;
	logic                  in_unusable;
	logic                  in_disp;
	logic                  in_echo;
	logic [15:0]           target;
	logic [hmmd_pkg::DISP_AW-1:0] disp_idx;
	hmmd_pkg::pend_t       pend_next;
	hmmd_pkg::store_wr_t   st_wr;
	hmmd_pkg::store_rd_t   st_rd;
	logic [7:0]            st_rdata;

	// Handshake.
	assign move_s1      = valid_s1 && (!out_valid_q || result.ready);
	assign access.ready = !clearing_q && (!valid_s1 || move_s1);
	assign take         = access.valid && access.ready;

	// Address decode.
	always_comb begin
		is_write    = (access.command == hmmd_pkg::CMD_WRITE);
		in_rom      = (access.bus_address < hmmd_pkg::ROM_END);
		in_unusable = (access.bus_address >= hmmd_pkg::UNUSABLE_START) &&
			(access.bus_address < hmmd_pkg::IO_START);
		in_disp     = (access.bus_address >= hmmd_pkg::DISP_FIRST) &&
			(access.bus_address <= hmmd_pkg::DISP_LAST);
		in_echo     = (access.bus_address >= hmmd_pkg::ECHO_START) &&
			(access.bus_address < hmmd_pkg::OAM_START);
		target      = in_echo ? (access.bus_address - hmmd_pkg::ECHO_OFFSET)
			: access.bus_address;
		disp_idx    = in_disp ? access.bus_address[hmmd_pkg::DISP_AW-1:0] : '0;
	end

	// Result fields known at acceptance; store read data comes from the registered read port.
	always_comb begin
		pend_next = '0;
		if (in_rom) begin
			pend_next.cart = !is_write;
			pend_next.drop = is_write;
		end else if (in_unusable) begin
			pend_next.drop     = is_write;
			pend_next.imm_byte = is_write ? 8'h00 : hmmd_pkg::OPEN_BUS;
		end else if (in_disp) begin
			pend_next.imm_byte = is_write ? 8'h00 : disp_q[disp_idx];
		end else begin
			pend_next.use_mem = !is_write;
		end
	end

	// Store ports: the clearing pass owns the write port after reset.
	always_comb begin
		st_wr = '0;
		st_rd = '0;
		if (clearing_q) begin
			st_wr.en   = 1'b1;
			st_wr.addr = clr_cnt_q;
			st_wr.data = 8'h00;
		end else begin
			st_wr.en   = take && is_write && !in_rom && !in_unusable && !in_disp;
			st_wr.addr = target[hmmd_pkg::STORE_AW-1:0];
			st_wr.data = access.write_byte;
		end
		st_rd.en   = take && pend_next.use_mem;
		st_rd.addr = target[hmmd_pkg::STORE_AW-1:0];
	end

	hmmd_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd      (st_rd),
		.rdata_q (st_rdata)
	);

	// Clearing pass over the byte store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Display register writes; a write to the scanline register clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hmmd_pkg::DISP_COUNT; i++) begin
				disp_q[i] <= 8'h00;
			end
		end else if (take && is_write && in_disp) begin
			disp_q[disp_idx] <= (access.bus_address == hmmd_pkg::DISP_LINE) ? 8'h00
				: access.write_byte;
		end
	end

	// Pending stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			pend_s1 <= pend_next;
		end
		if (move_s1) begin
			read_byte_q <= pend_s1.use_mem ? st_rdata : pend_s1.imm_byte;
			cart_q      <= pend_s1.cart;
			drop_q      <= pend_s1.drop;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.read_byte     = read_byte_q;
	assign result.to_cartridge  = cart_q;
	assign result.write_dropped = drop_q;

endmodule

`default_nettype wire

// ===== src/hmmd_checker.sv =====
// Port-level checks for the handheld memory map decoder, bound to its top level.
// Depends on handheld_memory_map_decoder and its channel interfaces.
`default_nettype none

module hmmd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] read_byte,
	input wire logic       to_cartridge,
	input wire logic       write_dropped
);

	// A stalled result word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) &&
		$stable(to_cartridge) && $stable(write_dropped))
		else $error("result word changed while stalled");

	// A cartridge read and a dropped write never come from one access.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(to_cartridge && write_dropped))
		else $error("cartridge and dropped flags both set");

	// A cartridge read returns no data from the block.
	a_cart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && to_cartridge |-> read_byte == 8'h00)
		else $error("cartridge read returned data");

	// A dropped write returns no data.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_dropped |-> read_byte == 8'h00)
		else $error("dropped write returned data");

endmodule

bind handheld_memory_map_decoder hmmd_checker u_hmmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.read_byte     (result.read_byte),
	.to_cartridge  (result.to_cartridge),
	.write_dropped (result.write_dropped)
);

`default_nettype wire
